// ----- src/mt_pkg.sv -----
// Shared types, constants and word functions for the MT19937 generator.
// Used by every module in src; depends on nothing else.
package mt_pkg;

  typedef logic [31:0] word_t;

  // Generator geometry (fixed by the algorithm)
  localparam int STATE_WORDS   = 624;
  localparam int TWIST_OFFSET  = 397;
  localparam int IDX_W         = $clog2(STATE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  localparam int KEY_DEPTH_DEF = 64;

  // Recurrence constants
  localparam word_t MAT_A     = 32'h9908b0df;
  localparam word_t HI_MASK   = 32'h80000000;
  localparam word_t LO_MASK   = 32'h7fffffff;
  localparam word_t SEED_MUL  = 32'd1812433253;
  localparam word_t PASS1_MUL = 32'd1664525;
  localparam word_t PASS2_MUL = 32'd1566083941;

  localparam word_t DEFAULT_SEED_RST = 32'd5489;

  // Input command codes
  localparam logic [1:0] CMD_SEED = 2'd0;
  localparam logic [1:0] CMD_KEY  = 2'd1;
  localparam logic [1:0] CMD_DRAW = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_DEFAULT_SEED = 1'd0;
  localparam logic [0:0] REG_TEMPER       = 1'd1;

  // Fixed taps of the state chain
  typedef struct packed {
    word_t first;   // oldest word
    word_t second;  // next to oldest
    word_t mid;     // word at the twist offset
    word_t last;    // most recently written word
  } mt_taps_t;

  function automatic word_t mix30(input word_t p);
    return p ^ (p >> 30);
  endfunction

  function automatic word_t twist_word(input word_t w0, input word_t w1, input word_t wm);
    word_t y;
    y = (w0 & HI_MASK) | (w1 & LO_MASK);
    return wm ^ (y >> 1) ^ (w1[0] ? MAT_A : 32'd0);
  endfunction

  function automatic word_t temper(input word_t x);
    word_t y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- src/mt_cell.sv -----
// One state word of the generator chain: loads its neighbor's word on shift.
// Depends on mt_pkg.
module mt_cell (
  input  logic          clk,
  input  logic          en,
  input  mt_pkg::word_t d,
  output mt_pkg::word_t q
);

  mt_pkg::word_t word_r;

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule

// ----- src/mt_chain.sv -----
// Row of mt_cell words forming the 624-word state shift chain.
// New words enter at the tail; fixed taps feed the control logic. Depends on mt_pkg, mt_cell.
module mt_chain (
  input  logic             clk,
  input  logic             shift_en,
  input  mt_pkg::word_t    feed_in,
  output mt_pkg::mt_taps_t taps
);

  localparam int N = mt_pkg::STATE_WORDS;

  mt_pkg::word_t word [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    mt_pkg::word_t d;
    if (i == N - 1) begin : g_tail
      assign d = feed_in;
    end else begin : g_body
      assign d = word[i+1];
    end
    mt_cell u_cell (
      .clk (clk),
      .en  (shift_en),
      .d   (d),
      .q   (word[i])
    );
  end

  assign taps.first  = word[0];
  assign taps.second = word[1];
  assign taps.mid    = word[mt_pkg::TWIST_OFFSET];
  assign taps.last   = word[N-1];

endmodule

// ----- src/mt_keystore.sv -----
// Key word store for array seeding: one write port, one registered read port.
// Depends on mt_pkg.
module mt_keystore #(
  parameter int DEPTH = mt_pkg::KEY_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  mt_pkg::word_t wdata,
  input  logic [AW-1:0] raddr,
  output mt_pkg::word_t rdata
);

  mt_pkg::word_t mem [DEPTH];
  mt_pkg::word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/mersenne_twister_mt19937.sv -----
// MT19937 generator. Draws stream at one word per cycle: the 624-word state lives in
// a shift chain of cells, and each draw computes one new word from the taps at offsets
// 0, 1 and 397, shifts it in at the tail and returns it (tempered unless temper_enable
// is 0) through an output register, so the input takes a draw whenever that register
// is empty or being taken. A draw is held off while a result waits under stall; other
// commands are still taken then. Seeding from one word shifts 624 words through the
// same chain, one multiply per cycle, and the input stalls until it is done. The first
// draw after reset without any seeding first seeds from the default word and then makes
// the draw itself, stalling the input throughout, longer if the output is held. Array
// seeding with the word marked last runs the single-word seed, both key passes (one word
// a cycle, with a wrap step per lap) and a final realign of almost two laps, stalling
// the input throughout. Key words not marked last are stored while the key store has
// room and leave the input free.
// Depends on mt_pkg, mt_chain, mt_cell, mt_keystore.
module mersenne_twister_mt19937 #(
  parameter int KEY_DEPTH = mt_pkg::KEY_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // input words
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_command,
  input  logic [31:0]   in_seed_value,
  input  logic          in_key_last,
  // result words
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   out_random_value,
  // configuration
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(KEY_DEPTH + 1);
  localparam int KMAX   = (KEY_DEPTH > mt_pkg::STATE_WORDS) ? KEY_DEPTH : mt_pkg::STATE_WORDS;
  localparam int KCNT_W = $clog2(KMAX + 1);
  localparam int IDX_W  = mt_pkg::IDX_W;

  typedef enum logic [2:0] {
    P_IDLE,
    P_SEED,
    P_ROT,
    P_PASS1,
    P_PASS2,
    P_FIX,
    P_DRAW
  } phase_t;

  // configuration registers
  mt_pkg::word_t default_seed_r;
  logic          temper_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_seed_r <= mt_pkg::DEFAULT_SEED_RST;
      temper_en_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        mt_pkg::REG_DEFAULT_SEED: default_seed_r <= cfg_data;
        mt_pkg::REG_TEMPER:       temper_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control state
  phase_t              phase_r, phase_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;        // word index at the chain head
  logic [KCNT_W-1:0]   kcnt_r, kcnt_nxt;      // steps left in a key pass
  logic [KIDX_W-1:0]   j_r, j_nxt;            // key word index
  logic [CNT_W-1:0]    len_r, len_nxt;        // key length of this seeding
  logic [CNT_W-1:0]    key_count_r, key_count_nxt;
  logic                seeded_r, seeded_nxt;
  logic                array_r, array_nxt;    // seeding continues into key passes
  logic                pend_r, pend_nxt;      // draw waits on seeding
  logic                fixed_r, fixed_nxt;    // head word already forced
  logic                out_valid_r;
  mt_pkg::word_t       out_data_r;

  logic                in_acc;
  logic                out_free;
  logic                key_room;
  logic                shift_en;
  logic                draw_fire;
  logic                key_we;
  mt_pkg::word_t       feed;
  mt_pkg::word_t       key_q;
  mt_pkg::mt_taps_t    taps;

  mt_pkg::word_t       seed_feed, pass1_feed, pass2_feed, twist_feed;
  logic [IDX_W-1:0]    idx_adv;
  logic [CNT_W-1:0]    j_inc;
  logic [KIDX_W-1:0]   j_adv;
  logic [KCNT_W-1:0]   k_init;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (phase_r != P_IDLE) ||
                    (out_valid_r && out_stall && (in_command == mt_pkg::CMD_DRAW));
  assign in_acc   = in_valid && !in_stall;
  assign key_room = key_count_r < CNT_W'(KEY_DEPTH);

  assign seed_feed  = (mt_pkg::mix30(taps.last) * mt_pkg::SEED_MUL) + 32'(idx_r);
  assign pass1_feed = (taps.first ^ (mt_pkg::mix30(taps.last) * mt_pkg::PASS1_MUL))
                      + key_q + 32'(j_r);
  assign pass2_feed = (taps.first ^ (mt_pkg::mix30(taps.last) * mt_pkg::PASS2_MUL))
                      - 32'(idx_r);
  assign twist_feed = mt_pkg::twist_word(taps.first, taps.second, taps.mid);

  assign idx_adv = (idx_r == mt_pkg::LAST_IDX) ? '0 : idx_r + IDX_W'(1);
  assign j_inc   = CNT_W'(j_r) + CNT_W'(1);
  assign j_adv   = (j_inc >= len_r) ? '0 : j_r + KIDX_W'(1);
  assign k_init  = (KCNT_W'(len_r) > KCNT_W'(mt_pkg::STATE_WORDS)) ?
                   KCNT_W'(len_r) : KCNT_W'(mt_pkg::STATE_WORDS);

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    kcnt_nxt      = kcnt_r;
    j_nxt         = j_r;
    len_nxt       = len_r;
    key_count_nxt = key_count_r;
    seeded_nxt    = seeded_r;
    array_nxt     = array_r;
    pend_nxt      = pend_r;
    fixed_nxt     = fixed_r;
    shift_en      = 1'b0;
    feed          = taps.first;
    draw_fire     = 1'b0;
    key_we        = 1'b0;

    case (phase_r)
      P_IDLE: begin
        if (in_acc) begin
          case (in_command)
            mt_pkg::CMD_SEED: begin
              shift_en   = 1'b1;
              feed       = in_seed_value;
              idx_nxt    = IDX_W'(1);
              phase_nxt  = P_SEED;
              array_nxt  = 1'b0;
              pend_nxt   = 1'b0;
              seeded_nxt = 1'b1;
            end
            mt_pkg::CMD_KEY: begin
              if (key_room) begin
                key_we        = 1'b1;
                key_count_nxt = key_count_r + CNT_W'(1);
              end
              if (in_key_last) begin
                len_nxt       = key_room ? key_count_r + CNT_W'(1) : key_count_r;
                key_count_nxt = '0;
                j_nxt         = '0;
                shift_en      = 1'b1;
                feed          = default_seed_r;
                idx_nxt       = IDX_W'(1);
                phase_nxt     = P_SEED;
                array_nxt     = 1'b1;
                pend_nxt      = 1'b0;
                seeded_nxt    = 1'b1;
              end
            end
            mt_pkg::CMD_DRAW: begin
              if (seeded_r) begin
                draw_fire = 1'b1;
              end else begin
                // seed from the default word first, then finish the draw
                shift_en   = 1'b1;
                feed       = default_seed_r;
                idx_nxt    = IDX_W'(1);
                phase_nxt  = P_SEED;
                array_nxt  = 1'b0;
                pend_nxt   = 1'b1;
                seeded_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      P_SEED: begin
        shift_en = 1'b1;
        feed     = seed_feed;
        idx_nxt  = idx_adv;
        if (idx_r == mt_pkg::LAST_IDX) begin
          if (array_r) begin
            phase_nxt = P_ROT;
          end else if (pend_r) begin
            phase_nxt = P_DRAW;
          end else begin
            phase_nxt = P_IDLE;
          end
        end
      end
      P_ROT: begin
        // move word 0 to the tail so word 1 heads the chain
        shift_en  = 1'b1;
        feed      = taps.first;
        idx_nxt   = IDX_W'(1);
        kcnt_nxt  = k_init;
        phase_nxt = P_PASS1;
      end
      P_PASS1, P_PASS2: begin
        shift_en = 1'b1;
        if (idx_r == '0) begin
          // wrap: word 0 takes the value of the last word
          feed    = taps.last;
          idx_nxt = IDX_W'(1);
        end else begin
          feed     = (phase_r == P_PASS1) ? pass1_feed : pass2_feed;
          idx_nxt  = idx_adv;
          kcnt_nxt = kcnt_r - KCNT_W'(1);
          if (phase_r == P_PASS1) begin
            j_nxt = j_adv;
          end
          if (kcnt_r == KCNT_W'(1)) begin
            if (phase_r == P_PASS1) begin
              phase_nxt = P_PASS2;
              kcnt_nxt  = KCNT_W'(mt_pkg::STATE_WORDS - 1);
            end else begin
              phase_nxt = P_FIX;
              fixed_nxt = 1'b0;
            end
          end
        end
      end
      P_FIX: begin
        if (fixed_r && (idx_r == '0)) begin
          phase_nxt = P_IDLE;
        end else begin
          shift_en = 1'b1;
          idx_nxt  = idx_adv;
          if (idx_r == '0) begin
            feed      = mt_pkg::HI_MASK;
            fixed_nxt = 1'b1;
          end else begin
            feed = taps.first;
          end
        end
      end
      P_DRAW: begin
        if (out_free) begin
          draw_fire = 1'b1;
          pend_nxt  = 1'b0;
          phase_nxt = P_IDLE;
        end
      end
      default: phase_nxt = P_IDLE;
    endcase

    if (draw_fire) begin
      shift_en = 1'b1;
      feed     = twist_feed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_IDLE;
      idx_r       <= '0;
      kcnt_r      <= '0;
      j_r         <= '0;
      len_r       <= '0;
      key_count_r <= '0;
      seeded_r    <= 1'b0;
      array_r     <= 1'b0;
      pend_r      <= 1'b0;
      fixed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      kcnt_r      <= kcnt_nxt;
      j_r         <= j_nxt;
      len_r       <= len_nxt;
      key_count_r <= key_count_nxt;
      seeded_r    <= seeded_nxt;
      array_r     <= array_nxt;
      pend_r      <= pend_nxt;
      fixed_r     <= fixed_nxt;
      if (draw_fire) begin
        out_valid_r <= 1'b1;
        out_data_r  <= temper_en_r ? mt_pkg::temper(twist_feed) : twist_feed;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_data_r;

  mt_chain u_chain (
    .clk      (clk),
    .shift_en (shift_en),
    .feed_in  (feed),
    .taps     (taps)
  );

  mt_keystore #(
    .DEPTH (KEY_DEPTH),
    .AW    (KIDX_W)
  ) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_count_r[KIDX_W-1:0]),
    .wdata (in_seed_value),
    .raddr (j_nxt),
    .rdata (key_q)
  );

  a_draw_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    draw_fire |-> out_free)
    else $error("draw overwrote a result still waiting");

  a_draw_shows: assert property (@(posedge clk) disable iff (!rst_n)
    draw_fire |=> out_valid_r)
    else $error("draw gave no result");

  a_busy_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != P_IDLE) |-> seeded_r)
    else $error("seeding in progress without seeded flag");

  a_pass_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_PASS1 || phase_r == P_PASS2) |-> (kcnt_r != '0))
    else $error("key pass ran out of steps");

  a_key_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_PASS1) |-> (CNT_W'(j_r) < len_r))
    else $error("key index beyond key length");

endmodule
